FILE: sv/tjb_pkg.sv
// Package for the timestamp jitter buffer: item structs, command codes and field widths.
// Used by the top level, front end, back end and testbench; depends on nothing.
package tjb_pkg;

  localparam logic [1:0] CmdPut = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdGet = 2'd2;

  localparam int unsigned ChunkW = 11;
  localparam logic [ChunkW-1:0] ChunkReset = 11'd320;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] timestamp;
    logic [8:0]  packet_length;
    logic [2:0]  write_slot;
    logic [7:0]  write_offset;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  granted_slot;
    logic        overflow_cleared;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [31:0] out_timestamp;
    logic        chunk_complete;
  } out_item_t;

endpackage

FILE: sv/timestamp_jitter_buffer.sv
// Top level of the timestamp jitter buffer: configuration register, front queue, back end.
// Depends on tjb_pkg, tjb_front and tjb_back.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  tjb_pkg::in_item_t
// out       output     out_valid_o/out_stall_i tjb_pkg::out_item_t
// cfg       input      cfg_valid_i/cfg_ready_o chunk_bytes (11 bit)
//
// Puts, writes and empty gets go from idle straight to the output state; a get that
// delivers a byte passes the read state first, for the registered payload memory read.
// Reset clears the slot table, fill counter and queue; the payload memory is not cleared.
// A stalled result holds in the output register; the front queue accepts until full.
module timestamp_jitter_buffer #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned SLOT_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tjb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tjb_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [10:0]        cfg_data_i
);

  logic [tjb_pkg::ChunkW-1:0] chunk_q;
  logic              q_valid, q_pop, busy;
  tjb_pkg::in_item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= tjb_pkg::ChunkReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      chunk_q <= cfg_data_i;
    end
  end

  tjb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  tjb_back #(.Slots(SLOTS), .SlotBytes(SLOT_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunk_bytes_i(chunk_q),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .busy_o       (busy)
  );

`ifndef NO_ASSERTIONS
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result without work");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop without item");
  a_chunk_reset: assert property (@(posedge clk_i)
    !rst_ni |=> chunk_q == tjb_pkg::ChunkReset || !rst_ni) else $error("chunk reset");
`endif

endmodule

FILE: sv/tjb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the payload store; depends on nothing.
module tjb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/tjb_front.sv
// Front end: accepts items and hands them on through a two-entry queue.
// Depends on tjb_pkg.
module tjb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tjb_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output tjb_pkg::in_item_t q_item_o
);

  tjb_pkg::in_item_t buf_q [2];
  logic              rd_q, rd_d, wr_q, wr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  always_comb begin
    rd_d  = rd_q ^ q_pop_i;
    wr_d  = wr_q ^ push;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> in_stall_o) else $error("full queue not stalled");
`endif

endmodule

FILE: sv/tjb_back.sv
// Back end: slot table, selection scan, payload store access and result register.
// Depends on tjb_pkg and tjb_ram.
module tjb_back #(
  parameter int unsigned Slots     = 8,
  parameter int unsigned SlotBytes = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tjb_pkg::ChunkW-1:0] chunk_bytes_i,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  tjb_pkg::in_item_t        q_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tjb_pkg::out_item_t       out_item_o,
  output logic                     busy_o
);

  localparam int unsigned SW = $clog2(Slots);
  localparam int unsigned BW = $clog2(SlotBytes);
  localparam int unsigned AW = SW + BW;
  localparam int unsigned LW = BW + 1;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [Slots-1:0]   used_q, used_d;
  logic [31:0]        latest_q, latest_d;
  logic [31:0]        time_q [Slots];
  logic [LW-1:0]      rem_q [Slots];
  logic [BW-1:0]      pos_q [Slots];
  logic [tjb_pkg::ChunkW-1:0] fill_q, fill_d;
  tjb_pkg::out_item_t res_q, res_d;

  logic [SW-1:0]      free_idx, best_idx;
  logic               any_free, found;
  logic [31:0]        best_time;
  logic [LW-1:0]      len_sat;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [7:0]         rdata;
  logic [tjb_pkg::ChunkW-1:0] fill_inc, limit;
  logic               start, do_put, do_get;
  logic [1:0]         cmd;

  assign cmd    = q_item_i.command;
  assign start  = (st_q == StIdle) && q_valid_i;
  assign do_put = start && (cmd == tjb_pkg::CmdPut);
  assign do_get = start && (cmd == tjb_pkg::CmdGet) && found;
  assign q_pop_o = start;
  assign busy_o  = (st_q != StIdle) || q_valid_i;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SW'(i);
        any_free = 1'b1;
      end
    end
    best_idx  = '0;
    found     = 1'b0;
    best_time = latest_q;
    for (int i = 0; i < Slots; i++) begin
      if (used_q[i] && time_q[i] <= best_time) begin
        best_time = time_q[i];
        best_idx  = SW'(i);
        found     = 1'b1;
      end
    end
  end

  assign len_sat = ({23'd0, q_item_i.packet_length} > 32'(SlotBytes)) ? LW'(SlotBytes)
                 : LW'(q_item_i.packet_length);

  assign we    = start && (cmd == tjb_pkg::CmdWrite)
               && ({29'd0, q_item_i.write_slot} < 32'(Slots))
               && ({24'd0, q_item_i.write_offset} < 32'(SlotBytes));
  assign waddr = AW'(({29'd0, q_item_i.write_slot} << BW) | {24'd0, q_item_i.write_offset});
  assign raddr = {best_idx, pos_q[best_idx]};

  tjb_ram #(.Width(8), .Depth(Slots * SlotBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(q_item_i.write_byte),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign limit    = (chunk_bytes_i == '0) ? tjb_pkg::ChunkW'(1) : chunk_bytes_i;
  assign fill_inc = fill_q + tjb_pkg::ChunkW'(1);

  always_comb begin
    st_d     = st_q;
    used_d   = used_q;
    latest_d = latest_q;
    fill_d   = fill_q;
    res_d    = res_q;
    unique case (st_q)
      StIdle: begin
        if (start) begin
          res_d = '0;
          unique case (cmd)
            tjb_pkg::CmdPut: begin
              res_d.overflow_cleared = !any_free;
              res_d.granted_slot = 3'(any_free ? free_idx : SW'(0));
              if (!any_free) used_d = '0;
              latest_d = q_item_i.timestamp;
              if (len_sat != '0) used_d[any_free ? free_idx : SW'(0)] = 1'b1;
              st_d = StOut;
            end
            tjb_pkg::CmdGet: begin
              if (found) begin
                res_d.byte_valid    = 1'b1;
                res_d.out_timestamp = time_q[best_idx];
                if (rem_q[best_idx] <= LW'(1)) used_d[best_idx] = 1'b0;
                if (fill_inc >= limit) begin
                  fill_d = '0;
                  res_d.chunk_complete = 1'b1;
                end else begin
                  fill_d = fill_inc;
                end
                st_d = StRead;
              end else begin
                st_d = StOut;
              end
            end
            default: st_d = StOut;
          endcase
        end
      end
      StRead: begin
        res_d.out_byte = rdata;
        st_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o = (st_q == StOut);
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      used_q   <= '0;
      latest_q <= '0;
      fill_q   <= '0;
      for (int i = 0; i < Slots; i++) begin
        time_q[i] <= '0;
        rem_q[i]  <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      st_q     <= st_d;
      used_q   <= used_d;
      latest_q <= latest_d;
      fill_q   <= fill_d;
      if (do_put) begin
        time_q[any_free ? free_idx : SW'(0)] <= q_item_i.timestamp;
        rem_q[any_free ? free_idx : SW'(0)]  <= len_sat;
        pos_q[any_free ? free_idx : SW'(0)]  <= '0;
      end else if (do_get) begin
        pos_q[best_idx] <= pos_q[best_idx] + BW'(1);
        if (rem_q[best_idx] != '0) rem_q[best_idx] <= rem_q[best_idx] - LW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> st_q == StIdle) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(res_q))
    else $error("result changed under stall");
  a_read_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRead |=> st_q == StOut) else $error("read not followed by output");
  a_found_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> used_q[best_idx]) else $error("selected slot not used");
`endif

endmodule

FILE: verif/tb_timestamp_jitter_buffer.sv
// Self-checking testbench for the timestamp jitter buffer: drives puts, writes, gets
// and invalid commands, predicts every result with its own slot model and checks
// them in a small scoreboard. Depends on tjb_pkg and timestamp_jitter_buffer.
module tb_timestamp_jitter_buffer;

  localparam int unsigned NumSlots  = 8;
  localparam int unsigned SlotBytes = 256;
  localparam int unsigned InBits    = $bits(tjb_pkg::in_item_t);
  localparam logic [1:0]  CmdBad    = 2'd3;

  class jitter_scoreboard;
    logic [10:0] chunk_len;
    logic [7:0]  used_mask;
    logic [31:0] newest_time;
    logic [31:0] slot_ts[NumSlots];
    logic [8:0]  bytes_left[NumSlots];
    logic [7:0]  read_pos[NumSlots];
    logic [7:0]  payload[NumSlots*SlotBytes];
    logic [10:0] fill;
    tjb_pkg::out_item_t pending[$];
    int          errors;

    function new();
      chunk_len = tjb_pkg::ChunkReset;
      used_mask = '0;
      newest_time = '0;
      fill = '0;
      errors = 0;
      foreach (slot_ts[i]) begin
        slot_ts[i] = '0;
        bytes_left[i] = '0;
        read_pos[i] = '0;
      end
    endfunction

    // Tells which slot and offset the next get would read, if any.
    function bit peek_get(output int slot, output int pos);
      logic [31:0] best_ts;
      slot = NumSlots;
      pos = 0;
      best_ts = newest_time;
      for (int i = 0; i < NumSlots; i++)
        if (used_mask[i] && slot_ts[i] <= best_ts) begin
          best_ts = slot_ts[i];
          slot = i;
        end
      if (slot < NumSlots) pos = int'(read_pos[slot]);
      return slot < NumSlots;
    endfunction

    function void note_item(tjb_pkg::in_item_t it);
      tjb_pkg::out_item_t r;
      int        slot;
      int        best;
      logic [31:0] best_ts;
      logic [8:0]  len;
      int          pos;
      int          lim;
      r = '0;
      if (it.command == tjb_pkg::CmdPut) begin
        slot = NumSlots;
        for (int i = NumSlots - 1; i >= 0; i--) if (!used_mask[i]) slot = i;
        if (slot == NumSlots) begin
          slot = 0;
          used_mask = '0;
          newest_time = '0;
          r.overflow_cleared = 1'b1;
        end
        len = (it.packet_length > SlotBytes) ? 9'(SlotBytes) : it.packet_length;
        slot_ts[slot] = it.timestamp;
        newest_time = it.timestamp;
        bytes_left[slot] = len;
        read_pos[slot] = '0;
        if (len != 0) used_mask[slot] = 1'b1;
        r.granted_slot = 3'(slot);
      end else if (it.command == tjb_pkg::CmdWrite) begin
        payload[it.write_slot*SlotBytes + it.write_offset] = it.write_byte;
      end else if (it.command == tjb_pkg::CmdGet) begin
        best = NumSlots;
        best_ts = newest_time;
        for (int i = 0; i < NumSlots; i++)
          if (used_mask[i] && slot_ts[i] <= best_ts) begin
            best_ts = slot_ts[i];
            best = i;
          end
        if (best < NumSlots) begin
          pos = int'(read_pos[best]);
          lim = (chunk_len == 0) ? 1 : int'(chunk_len);
          r.byte_valid = 1'b1;
          r.out_byte = payload[best*SlotBytes + pos];
          r.out_timestamp = slot_ts[best];
          read_pos[best] = 8'(pos + 1);
          if (bytes_left[best] > 0) bytes_left[best]--;
          if (bytes_left[best] == 0) used_mask[best] = 1'b0;
          fill = fill + 11'd1;
          if (fill >= lim) begin
            fill = '0;
            r.chunk_complete = 1'b1;
          end
        end
      end
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(tjb_pkg::out_item_t got);
      tjb_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected item", 32'(got), '0);
        return;
      end
      want = pending.pop_front();
      if (got.granted_slot !== want.granted_slot)
        report("granted_slot", 32'(got.granted_slot), 32'(want.granted_slot));
      if (got.overflow_cleared !== want.overflow_cleared)
        report("overflow_cleared", 32'(got.overflow_cleared), 32'(want.overflow_cleared));
      if (got.byte_valid !== want.byte_valid)
        report("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
      if (got.out_byte !== want.out_byte)
        report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      if (got.out_timestamp !== want.out_timestamp)
        report("out_timestamp", got.out_timestamp, want.out_timestamp);
      if (got.chunk_complete !== want.chunk_complete)
        report("chunk_complete", 32'(got.chunk_complete), 32'(want.chunk_complete));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  tjb_pkg::in_item_t  in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  tjb_pkg::out_item_t out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;

  jitter_scoreboard sb = new();
  bit  hold_req = 1'b0;
  logic hold_active = 1'b0;
  bit  stim_done = 1'b0;
  // Bytes known to be written, so that a get never reads a byte never stored.
  bit  written[NumSlots][SlotBytes];
  int  burst_left = 0;

  timestamp_jitter_buffer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i, .out_valid_o, .out_stall_i,
    .out_item_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    out_stall_i <= hold_active || (($urandom_range(0, 9) < 3) && !stim_done);
  end

  // Long hold-off on the result side, counted here once requested.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  function automatic tjb_pkg::in_item_t rand_item();
    return InBits'({$urandom, $urandom});
  endfunction

  task send_item(tjb_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  task stop_input();
    in_valid_i <= 1'b0;
  endtask

  task put_packet(logic [31:0] ts, logic [8:0] len);
    tjb_pkg::in_item_t it;
    it = rand_item();
    it.command = tjb_pkg::CmdPut;
    it.timestamp = ts;
    it.packet_length = len;
    send_item(it);
  endtask

  task write_byte(int slot, int off, logic [7:0] val);
    tjb_pkg::in_item_t it;
    it = rand_item();
    it.command = tjb_pkg::CmdWrite;
    it.write_slot = 3'(slot);
    it.write_offset = 8'(off);
    it.write_byte = val;
    send_item(it);
    written[slot][off] = 1'b1;
  endtask

  // The byte that a get will read is written first if it has never been stored.
  task get_byte();
    tjb_pkg::in_item_t it;
    int slot;
    int pos;
    if (sb.peek_get(slot, pos) && !written[slot][pos]) write_byte(slot, pos, 8'($urandom));
    it = rand_item();
    it.command = tjb_pkg::CmdGet;
    send_item(it);
  endtask

  task drain_and_config(logic [10:0] val);
    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.chunk_len = val;
  endtask

  // A packet stream: puts and gets interleaved at random, with occasional writes and noise.
  task random_phase(int n);
    tjb_pkg::in_item_t it;
    int       k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30)
        put_packet(($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 40)),
                   ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                               : 9'($urandom_range(0, 6)));
      else if (k < 85) get_byte();
      else if (k < 95) write_byte($urandom_range(0, 7), $urandom_range(0, 255), 8'($urandom));
      else begin
        it = rand_item();
        it.command = CmdBad;
        send_item(it);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    put_packet(32'hFFFF_FFFF, 9'd1);
    get_byte();
    put_packet(32'h0, 9'd0);
    get_byte();
    put_packet(32'd5, 9'd256);
    put_packet(32'd5, 9'd511);
    get_byte();
    get_byte();
    for (int i = 0; i < 8; i++) put_packet(32'(i), 9'd2);
    get_byte();
    write_byte(7, 255, 8'hFF);
    write_byte(0, 0, 8'h00);
    get_byte();
    drain_and_config(11'd0);
    random_phase(60);
    drain_and_config(11'd1);
    random_phase(60);
    // Long hold-off on the result side so the block fills and stalls its input.
    hold_req = 1'b1;
    random_phase(40);
    drain_and_config(11'd1024);
    random_phase(60);
    drain_and_config(11'h7FF);
    random_phase(40);
    drain_and_config(11'd3);
    random_phase(110);
    stop_input();
    stim_done = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("tb_timestamp_jitter_buffer: PASS");
    else $display("tb_timestamp_jitter_buffer: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_timestamp_jitter_buffer: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
sv/tjb_pkg.sv
sv/tjb_ram.sv
sv/tjb_front.sv
sv/tjb_back.sv
sv/timestamp_jitter_buffer.sv
verif/tb_timestamp_jitter_buffer.sv
